// ----- rtl/core/dtti_pkg.sv -----
package dtti_pkg;

  // parse phases
  localparam logic [2:0] PH_START       = 3'd0;
  localparam logic [2:0] PH_AFTER_MINUS = 3'd1;
  localparam logic [2:0] PH_ZERO        = 3'd2;
  localparam logic [2:0] PH_SKIP        = 3'd3;
  localparam logic [2:0] PH_DIGITS      = 3'd4;
  localparam logic [2:0] PH_DONE_OK     = 3'd5;
  localparam logic [2:0] PH_DONE_FAIL   = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_TARGET_TYPE   = 2'd0;
  localparam logic [1:0] CFG_CONVERT_LIMIT = 2'd1;
  localparam logic [1:0] CFG_SKIP_ZEROS    = 2'd2;

  localparam logic [2:0] TARGET_RESET = 3'd2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [7:0] LEN_SIGNED_NARROW   = 8'd11;
  localparam logic [7:0] LEN_WIDE            = 8'd20;
  localparam logic [7:0] LEN_UNSIGNED_NARROW = 8'd10;
  localparam logic [7:0] POS_MAX             = 8'd255;

  typedef struct packed {
    logic [2:0] target_type;
    logic [7:0] convert_limit;
    logic       skip_leading_zeros;
  } cfg_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        ok;
  } result_t;

  function automatic logic [7:0] max_len(input logic [2:0] target);
    logic [7:0] len;
    if (target[1:0] == 2'd3) begin
      len = LEN_WIDE;
    end else if (target[2]) begin
      len = LEN_UNSIGNED_NARROW;
    end else begin
      len = LEN_SIGNED_NARROW;
    end
    return len;
  endfunction

  // range check of the accumulated magnitude against the target
  function automatic result_t finish(input logic [2:0] target, input logic minus,
                                     input logic [63:0] mag, input logic ovf);
    result_t    res;
    logic [63:0] half;
    logic [63:0] maxv;
    case (target[1:0])
      2'd0: begin
        half = 64'h0000_0000_0000_0080;
        maxv = 64'h0000_0000_0000_00ff;
      end
      2'd1: begin
        half = 64'h0000_0000_0000_8000;
        maxv = 64'h0000_0000_0000_ffff;
      end
      2'd2: begin
        half = 64'h0000_0000_8000_0000;
        maxv = 64'h0000_0000_ffff_ffff;
      end
      default: begin
        half = 64'h8000_0000_0000_0000;
        maxv = 64'hffff_ffff_ffff_ffff;
      end
    endcase
    res.value_bits = 64'd0;
    res.ok         = 1'b0;
    if (!ovf) begin
      if (!target[2]) begin
        if (minus) begin
          if (mag <= half) begin
            res.value_bits = 64'd0 - mag;
            res.ok         = 1'b1;
          end
        end else if (mag <= half - 64'd1) begin
          res.value_bits = mag;
          res.ok         = 1'b1;
        end
      end else if (!(minus && mag != 64'd0) && mag <= maxv) begin
        res.value_bits = mag;
        res.ok         = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/decimal_text_to_integer.sv -----
// channel  | direction | payload                        | handshake
// in       | input     | in_text_byte[7:0]              | in_valid / in_ready
// out      | output    | out_value_bits[63:0], out_ok   | out_valid / out_ready
// cfg      | input     | cfg_index[1:0], cfg_data[7:0]  | cfg_valid / cfg_ready
//
// One byte per cycle while no terminator waits on a held result; a beat is held in the
// input register, and a terminator's result is loaded into the output register as it is taken.
// Per-byte work is a single pass: shift-add times ten plus digit, one 64-bit range check.
// Synchronous active-low reset clears all control state; config returns to its reset values.
// A held result stalls a terminator in the input register and every beat behind it;
// other bytes never wait on the output. cfg_ready is always high.
module decimal_text_to_integer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value_bits,
  output logic        out_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  dtti_pkg::cfg_t    cfg_r;
  dtti_pkg::result_t res;
  logic              s_valid;
  logic [7:0]        s_byte;
  logic              s_take;
  logic              slot_free;
  logic              load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_type        <= dtti_pkg::TARGET_RESET;
      cfg_r.convert_limit      <= 8'd0;
      cfg_r.skip_leading_zeros <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtti_pkg::CFG_TARGET_TYPE:   cfg_r.target_type        <= cfg_data[2:0];
        dtti_pkg::CFG_CONVERT_LIMIT: cfg_r.convert_limit      <= cfg_data;
        dtti_pkg::CFG_SKIP_ZEROS:    cfg_r.skip_leading_zeros <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // terminator beats need a free output slot, other beats never wait
  assign s_take = s_valid && ((s_byte != dtti_pkg::CHAR_NUL) || slot_free);
  assign load   = s_take && (s_byte == dtti_pkg::CHAR_NUL);

  dtti_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .s_valid      (s_valid),
    .s_byte       (s_byte),
    .s_take       (s_take)
  );

  dtti_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .fire      (s_take),
    .text_byte (s_byte),
    .res       (res)
  );

  dtti_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .res_in         (res),
    .slot_free      (slot_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value_bits (out_value_bits),
    .out_ok         (out_ok)
  );

endmodule

// ----- rtl/core/dtti_in_stage.sv -----
module dtti_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  output logic       s_valid,
  output logic [7:0] s_byte,
  input  logic       s_take
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || s_take;
  assign s_valid  = valid_r;
  assign s_byte   = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (s_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_text_byte;
    end
  end

endmodule

// ----- rtl/core/dtti_parse.sv -----
module dtti_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  dtti_pkg::cfg_t   cfg,
  input  logic             fire,
  input  logic [7:0]       text_byte,
  output dtti_pkg::result_t res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic        minus_r, minus_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic        ovf_r, ovf_nxt;

  logic        term;
  logic        is_digit;
  logic [3:0]  digit;
  logic [7:0]  len;
  logic        pos_over;
  logic        allows_more;
  logic [67:0] acc;

  assign term     = (text_byte == dtti_pkg::CHAR_NUL);
  assign is_digit = (text_byte >= dtti_pkg::CHAR_ZERO) && (text_byte <= dtti_pkg::CHAR_NINE);
  assign digit    = text_byte[3:0];
  assign len      = dtti_pkg::max_len(cfg.target_type);
  assign pos_over = (pos_r >= len);
  assign allows_more = (cfg.convert_limit == 8'd0) ||
                       (({1'b0, pos_r} + 9'd1) < {1'b0, cfg.convert_limit});

  // mag * 10 + digit, carry-out above bit 63 flags overflow
  assign acc = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {64'd0, digit};

  always_comb begin
    case (phase_r)
      dtti_pkg::PH_ZERO: begin
        res = dtti_pkg::finish(cfg.target_type, minus_r, 64'd0, 1'b0);
      end
      dtti_pkg::PH_SKIP: begin
        if (!pos_over) begin
          res = dtti_pkg::finish(cfg.target_type, minus_r, 64'd0, 1'b0);
        end else begin
          res = '0;
        end
      end
      dtti_pkg::PH_DIGITS, dtti_pkg::PH_DONE_OK: begin
        res = dtti_pkg::finish(cfg.target_type, minus_r, mag_r, ovf_r);
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    minus_nxt = minus_r;
    mag_nxt   = mag_r;
    ovf_nxt   = ovf_r;
    if (fire) begin
      if (term) begin
        phase_nxt = dtti_pkg::PH_START;
        pos_nxt   = 8'd0;
        minus_nxt = 1'b0;
        mag_nxt   = 64'd0;
        ovf_nxt   = 1'b0;
      end else begin
        case (phase_r)
          dtti_pkg::PH_START, dtti_pkg::PH_AFTER_MINUS: begin
            if (phase_r == dtti_pkg::PH_START && text_byte == dtti_pkg::CHAR_MINUS) begin
              minus_nxt = 1'b1;
              phase_nxt = dtti_pkg::PH_AFTER_MINUS;
            end else if (text_byte == dtti_pkg::CHAR_ZERO) begin
              mag_nxt   = 64'd0;
              phase_nxt = (cfg.convert_limit == 8'd1) ? dtti_pkg::PH_DONE_OK
                                                      : dtti_pkg::PH_ZERO;
            end else if (!is_digit) begin
              phase_nxt = dtti_pkg::PH_DONE_FAIL;
            end else begin
              mag_nxt   = {60'd0, digit};
              phase_nxt = allows_more ? dtti_pkg::PH_DIGITS : dtti_pkg::PH_DONE_OK;
            end
          end
          dtti_pkg::PH_ZERO, dtti_pkg::PH_SKIP: begin
            if (phase_r == dtti_pkg::PH_ZERO && !cfg.skip_leading_zeros) begin
              phase_nxt = dtti_pkg::PH_DONE_FAIL;
            end else if (pos_over) begin
              phase_nxt = dtti_pkg::PH_DONE_FAIL;
            end else if (text_byte == dtti_pkg::CHAR_ZERO) begin
              phase_nxt = dtti_pkg::PH_SKIP;
            end else if (!is_digit) begin
              phase_nxt = dtti_pkg::PH_DONE_FAIL;
            end else begin
              mag_nxt   = {60'd0, digit};
              phase_nxt = allows_more ? dtti_pkg::PH_DIGITS : dtti_pkg::PH_DONE_OK;
            end
          end
          dtti_pkg::PH_DIGITS: begin
            if (pos_over || !is_digit) begin
              phase_nxt = dtti_pkg::PH_DONE_FAIL;
            end else begin
              mag_nxt = acc[63:0];
              if (|acc[67:64]) begin
                ovf_nxt = 1'b1;
              end
              if (!allows_more) begin
                phase_nxt = dtti_pkg::PH_DONE_OK;
              end
            end
          end
          default: begin
          end
        endcase
        if (pos_r != dtti_pkg::POS_MAX) begin
          pos_nxt = pos_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dtti_pkg::PH_START;
      pos_r   <= 8'd0;
      minus_r <= 1'b0;
      mag_r   <= 64'd0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      minus_r <= minus_nxt;
      mag_r   <= mag_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

`ifndef SYNTHESIS
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && term |=> phase_r == dtti_pkg::PH_START && pos_r == 8'd0 && !minus_r)
    else $error("string state not cleared after terminator");

  a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !term |=> pos_r != 8'd0)
    else $error("character position did not advance");

  a_fail_phase_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == dtti_pkg::PH_DONE_FAIL || phase_r == dtti_pkg::PH_START ||
     phase_r == dtti_pkg::PH_AFTER_MINUS) |-> !res.ok)
    else $error("ok raised from a failing phase");

  a_ovf_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r && (phase_r == dtti_pkg::PH_DIGITS || phase_r == dtti_pkg::PH_DONE_OK) |-> !res.ok)
    else $error("ok raised after magnitude overflow");

  a_minus_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == dtti_pkg::PH_AFTER_MINUS |-> minus_r)
    else $error("after-minus phase without minus flag");
`endif

endmodule

// ----- rtl/core/dtti_out_stage.sv -----
module dtti_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  dtti_pkg::result_t res_in,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_value_bits,
  output logic              out_ok
);

  logic              valid_r;
  logic              valid_nxt;
  dtti_pkg::result_t res_r;

  assign slot_free      = !valid_r || out_ready;
  assign out_valid      = valid_r;
  assign out_value_bits = res_r.value_bits;
  assign out_ok         = res_r.ok;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule
